// ----- design/intel_hex_record_parser_defines.svh -----
// assertion macros shared by the checker
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

// property checked only outside reset
`define IHEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define IHEX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/ihex_pkg.sv -----
`timescale 1ns / 1ps
package ihex_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_EOF    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_START  = 3'd1,
    ERR_COUNT     = 3'd2,
    ERR_ADDRESS   = 3'd3,
    ERR_TYPE      = 3'd4,
    ERR_DATA      = 3'd5,
    ERR_CHECKSUM  = 3'd6,
    ERR_TRUNCATED = 3'd7
  } err_e;

  // parser phases
  typedef enum logic [3:0] {
    PH_WAIT   = 4'd0,
    PH_COUNT  = 4'd1,
    PH_ADDRHI = 4'd2,
    PH_ADDRLO = 4'd3,
    PH_TYPE   = 4'd4,
    PH_DATA   = 4'd5,
    PH_CHECK  = 4'd6,
    PH_AFTER  = 4'd7,
    PH_DONE   = 4'd8
  } phase_e;

  localparam logic [7:0] CharColon   = 8'h3a;
  localparam logic [7:0] CharNewline = 8'h0a;
  localparam logic [7:0] RecTypeData = 8'h00;
  localparam logic [7:0] RecTypeEof  = 8'h01;
  localparam logic [15:0] LineMax    = 16'hffff;

  // input item
  typedef struct packed {
    logic       start_of_file;
    logic [7:0] char_code;
  } in_item_t;

  // result item
  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_length;
    err_e        error_code;
    logic [15:0] line_number;
  } out_item_t;

  // classified character passed from front to back
  typedef struct packed {
    logic       sof;
    logic       nl;
    logic       colon;
    logic       hex;
    logic [3:0] nib;
  } tok_t;

endpackage

// ----- design/ihex_front.sv -----
`timescale 1ns / 1ps
module ihex_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  ihex_pkg::in_item_t in_item_i,
  output logic             tok_vld_o,
  output ihex_pkg::tok_t   tok_o,
  input  logic             tok_pop_i
);
  import ihex_pkg::*;

  tok_t       tok_in;
  tok_t       q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  logic [7:0] c;

  // classify the character: hex nibble, newline, colon
  always_comb begin
    c             = in_item_i.char_code;
    tok_in.sof    = in_item_i.start_of_file;
    tok_in.nl     = (c == CharNewline);
    tok_in.colon  = (c == CharColon);
    tok_in.hex    = 1'b1;
    tok_in.nib    = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      tok_in.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      tok_in.nib = c[3:0] + 4'd9;
    end else begin
      tok_in.hex = 1'b0;
    end
  end

  // two-entry token queue
  assign full      = (cnt_q == 2'd2);
  assign wr_en     = push && !full;
  assign tok_vld_o = (cnt_q != 2'd0);
  assign rd_en     = tok_pop_i && tok_vld_o;
  assign tok_o     = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // token storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wr_ptr_q] <= tok_in;
    end
  end

endmodule

// ----- design/ihex_back.sv -----
`timescale 1ns / 1ps
module ihex_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_vld_i,
  input  ihex_pkg::tok_t      tok_i,
  output logic                tok_pop_o,
  output logic                empty,
  input  logic                pop,
  output ihex_pkg::out_item_t out_item_o
);
  import ihex_pkg::*;

  // parser state
  phase_e      phase_q, phase_d, ph;
  logic        second_q, second_d, sec;
  logic [3:0]  high_q, high_d, hi;
  logic [7:0]  count_q, count_d, cnt;
  logic [7:0]  left_q, left_d, lft;
  logic [15:0] addr_q, addr_d, adr;
  logic [7:0]  off_q, off_d, off;
  logic [7:0]  sum_q, sum_d, sum;
  logic [15:0] done_q, done_d, dn;
  logic        halt_q, halt_d, hlt;

  logic        take;
  logic        res_vld;
  kind_e       res_kind;
  err_e        res_err;
  logic        res_is_data;
  logic [15:0] data_addr;
  logic [7:0]  b;
  out_item_t   res;

  // output queue
  out_item_t   oq_q [2];
  logic        owr_q, ord_q;
  logic [1:0]  ocnt_q, ocnt_d;
  logic        opush, opop;

  assign take      = tok_vld_i && (ocnt_q != 2'd2);
  assign tok_pop_o = take;

  // state seen by this character, start of file clears first
  always_comb begin
    ph  = tok_i.sof ? PH_WAIT : phase_q;
    sec = tok_i.sof ? 1'b0 : second_q;
    hi  = tok_i.sof ? 4'd0 : high_q;
    cnt = tok_i.sof ? 8'd0 : count_q;
    lft = tok_i.sof ? 8'd0 : left_q;
    adr = tok_i.sof ? 16'd0 : addr_q;
    off = tok_i.sof ? 8'd0 : off_q;
    sum = tok_i.sof ? 8'd0 : sum_q;
    dn  = tok_i.sof ? 16'd0 : done_q;
    hlt = tok_i.sof ? 1'b0 : halt_q;
  end

  // parser step
  always_comb begin
    phase_d     = ph;
    second_d    = sec;
    high_d      = hi;
    count_d     = cnt;
    left_d      = lft;
    addr_d      = adr;
    off_d       = off;
    sum_d       = sum;
    done_d      = dn;
    halt_d      = hlt;
    res_vld     = 1'b0;
    res_kind    = KIND_ERROR;
    res_err     = ERR_NONE;
    res_is_data = 1'b0;
    data_addr   = adr + {8'd0, off};
    b           = {hi, tok_i.nib};
    if (!hlt && ph != PH_DONE) begin
      case (ph)
        PH_WAIT: begin
          if (tok_i.nl) begin
            halt_d  = 1'b1;
            res_vld = 1'b1;
            res_err = ERR_NO_START;
          end else if (tok_i.colon) begin
            phase_d  = PH_COUNT;
            second_d = 1'b0;
            high_d   = 4'd0;
            sum_d    = 8'd0;
            addr_d   = 16'd0;
            count_d  = 8'd0;
            left_d   = 8'd0;
            off_d    = 8'd0;
          end
        end
        PH_AFTER: begin
          if (tok_i.nl) begin
            phase_d = PH_WAIT;
            count_d = 8'd0;
            addr_d  = 16'd0;
          end
        end
        default: begin
          if (tok_i.nl) begin
            halt_d  = 1'b1;
            res_vld = 1'b1;
            res_err = ERR_TRUNCATED;
          end else if (!tok_i.hex) begin
            halt_d  = 1'b1;
            res_vld = 1'b1;
            case (ph)
              PH_COUNT:  res_err = ERR_COUNT;
              PH_ADDRHI: res_err = ERR_ADDRESS;
              PH_ADDRLO: res_err = ERR_ADDRESS;
              PH_TYPE:   res_err = ERR_TYPE;
              PH_DATA:   res_err = ERR_DATA;
              default:   res_err = ERR_CHECKSUM;
            endcase
          end else if (!sec) begin
            high_d   = tok_i.nib;
            second_d = 1'b1;
          end else begin
            second_d = 1'b0;
            // full byte assembled
            case (ph)
              PH_COUNT: begin
                count_d = b;
                left_d  = b;
                sum_d   = b;
                phase_d = PH_ADDRHI;
              end
              PH_ADDRHI: begin
                addr_d  = {b, 8'd0};
                sum_d   = sum + b;
                phase_d = PH_ADDRLO;
              end
              PH_ADDRLO: begin
                addr_d  = {adr[15:8], b};
                sum_d   = sum + b;
                phase_d = PH_TYPE;
              end
              PH_TYPE: begin
                if (b == RecTypeEof) begin
                  phase_d  = PH_DONE;
                  res_vld  = 1'b1;
                  res_kind = KIND_EOF;
                end else if (b != RecTypeData) begin
                  halt_d  = 1'b1;
                  res_vld = 1'b1;
                  res_err = ERR_TYPE;
                end else begin
                  off_d   = 8'd0;
                  phase_d = (lft != 8'd0) ? PH_DATA : PH_CHECK;
                end
              end
              PH_DATA: begin
                sum_d       = sum + b;
                off_d       = off + 8'd1;
                left_d      = lft - 8'd1;
                phase_d     = (lft == 8'd1) ? PH_CHECK : PH_DATA;
                res_vld     = 1'b1;
                res_kind    = KIND_DATA;
                res_is_data = 1'b1;
              end
              default: begin
                if ((sum + b) != 8'd0) begin
                  halt_d  = 1'b1;
                  res_vld = 1'b1;
                  res_err = ERR_CHECKSUM;
                end else begin
                  done_d   = (dn != LineMax) ? dn + 16'd1 : dn;
                  phase_d  = PH_AFTER;
                  res_vld  = 1'b1;
                  res_kind = KIND_ACCEPT;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // assemble the result item
  always_comb begin
    res.kind          = res_kind;
    res.address       = res_is_data ? data_addr : addr_d;
    res.data_byte     = res_is_data ? b : 8'd0;
    res.record_length = count_d;
    res.error_code    = res_err;
    res.line_number   = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      second_q <= 1'b0;
      high_q   <= 4'd0;
      count_q  <= 8'd0;
      left_q   <= 8'd0;
      addr_q   <= 16'd0;
      off_q    <= 8'd0;
      sum_q    <= 8'd0;
      done_q   <= 16'd0;
      halt_q   <= 1'b0;
    end else if (take) begin
      phase_q  <= phase_d;
      second_q <= second_d;
      high_q   <= high_d;
      count_q  <= count_d;
      left_q   <= left_d;
      addr_q   <= addr_d;
      off_q    <= off_d;
      sum_q    <= sum_d;
      done_q   <= done_d;
      halt_q   <= halt_d;
    end
  end

  // two-entry result queue
  assign opush      = take && res_vld;
  assign empty      = (ocnt_q == 2'd0);
  assign opop       = pop && !empty;
  assign out_item_o = oq_q[ord_q];
  assign ocnt_d     = ocnt_q + {1'b0, opush} - {1'b0, opop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      owr_q  <= owr_q ^ opush;
      ord_q  <= ord_q ^ opop;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owr_q] <= res;
    end
  end

endmodule

// ----- design/intel_hex_record_parser.sv -----
// characters wait in the character queue; results are registered in the result queue
// one character per cycle while the result queue has room
// full rises only when the two-entry character queue backs up behind pop
// reset: asynchronous, active low; clears both queues and the parser state
`timescale 1ns / 1ps
module intel_hex_record_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ihex_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ihex_pkg::out_item_t out_item_o
);
  import ihex_pkg::*;

  logic tok_vld;
  logic tok_pop;
  tok_t tok;

  // character classify and queue
  ihex_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .tok_vld_o (tok_vld),
    .tok_o     (tok),
    .tok_pop_i (tok_pop)
  );

  // record parser and result queue
  ihex_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_vld_i  (tok_vld),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ----- design/ihex_checker.sv -----
`timescale 1ns / 1ps
`include "intel_hex_record_parser_defines.svh"
module ihex_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input ihex_pkg::out_item_t out_item_o
);
  import ihex_pkg::*;

  kind_e      kind;
  err_e       code;
  logic [7:0] dbyte;

  // fields of the waiting item
  assign kind  = out_item_o.kind;
  assign code  = out_item_o.error_code;
  assign dbyte = out_item_o.data_byte;

  // queues come up empty from reset
  `IHEX_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (empty && !full), "queues not empty in reset")

  // only error items carry an error code
  `IHEX_ASSERT(a_err_code, (!empty && kind != KIND_ERROR) |-> (code == ERR_NONE), "bad error code")

  // only data items carry a byte
  `IHEX_ASSERT(a_data_zero, (!empty && kind != KIND_DATA) |-> (dbyte == 8'd0), "stray data byte")

  // a waiting item holds until popped
  `IHEX_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_item_o)), "waiting item changed")

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ihex_pkg::*;

  localparam int CharTarget  = 1750;
  localparam int CycleLimit  = 100000;
  localparam int QuietFirst  = 1000;
  localparam int QuietLast   = 1600;
  localparam int DrainCycles = 20;
  localparam logic [7:0] CharReturn = 8'h0d;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  intel_hex_record_parser dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_item_i,
    .empty,
    .pop,
    .out_item_o
  );

  always #5 clk_i = ~clk_i;

  in_item_t  char_feed[$];
  out_item_t pending_events[$];
  int        cycle_count    = 0;
  int        mismatch_count = 0;
  int        stim_count     = 0;
  bit        gen_halted     = 1'b0;
  logic      char_taken     = 1'b0;

  // parser state mirrored in the testbench
  phase_e      ps_phase;
  logic        ps_second;
  logic [3:0]  ps_high;
  logic [7:0]  ps_count;
  logic [7:0]  ps_left;
  logic [7:0]  ps_offset;
  logic [7:0]  ps_sum;
  logic [15:0] ps_addr;
  logic [15:0] ps_records;
  logic        ps_halted;

  function automatic void clear_parser();
    ps_phase   = PH_WAIT;
    ps_second  = 1'b0;
    ps_high    = 4'h0;
    ps_count   = 8'h00;
    ps_left    = 8'h00;
    ps_offset  = 8'h00;
    ps_sum     = 8'h00;
    ps_addr    = 16'h0000;
    ps_records = 16'h0000;
    ps_halted  = 1'b0;
  endfunction

  // valid flag in bit 4, nibble below
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'h00;
  endfunction

  function automatic void post_event(kind_e k, logic [15:0] a, logic [7:0] d, err_e e);
    out_item_t r;
    r.kind          = k;
    r.address       = a;
    r.data_byte     = d;
    r.record_length = ps_count;
    r.error_code    = e;
    r.line_number   = ps_records;
    pending_events = {pending_events, r};
  endfunction

  function automatic void raise_error(err_e e);
    ps_halted = 1'b1;
    post_event(KIND_ERROR, ps_addr, 8'h00, e);
  endfunction

  function automatic err_e field_error();
    case (ps_phase)
      PH_COUNT:             return ERR_COUNT;
      PH_ADDRHI, PH_ADDRLO: return ERR_ADDRESS;
      PH_TYPE:              return ERR_TYPE;
      PH_DATA:              return ERR_DATA;
      default:              return ERR_CHECKSUM;
    endcase
  endfunction

  // one decoded byte of the record
  function automatic void take_byte(logic [7:0] b);
    logic [7:0] total;
    case (ps_phase)
      PH_COUNT: begin
        ps_count = b;
        ps_left  = b;
        ps_sum   = b;
        ps_phase = PH_ADDRHI;
      end
      PH_ADDRHI: begin
        ps_addr  = {b, 8'h00};
        ps_sum   = ps_sum + b;
        ps_phase = PH_ADDRLO;
      end
      PH_ADDRLO: begin
        ps_addr[7:0] = b;
        ps_sum       = ps_sum + b;
        ps_phase     = PH_TYPE;
      end
      PH_TYPE: begin
        if (b == RecTypeEof) begin
          ps_phase = PH_DONE;
          post_event(KIND_EOF, ps_addr, 8'h00, ERR_NONE);
        end else if (b != RecTypeData) begin
          raise_error(ERR_TYPE);
        end else begin
          ps_offset = 8'h00;
          ps_phase  = (ps_left != 8'h00) ? PH_DATA : PH_CHECK;
        end
      end
      PH_DATA: begin
        post_event(KIND_DATA, ps_addr + {8'h00, ps_offset}, b, ERR_NONE);
        ps_sum    = ps_sum + b;
        ps_offset = ps_offset + 8'h01;
        ps_left   = ps_left - 8'h01;
        if (ps_left == 8'h00) ps_phase = PH_CHECK;
      end
      default: begin
        total = ps_sum + b;
        if (total != 8'h00) begin
          raise_error(ERR_CHECKSUM);
        end else begin
          if (ps_records != LineMax) ps_records = ps_records + 16'h0001;
          ps_phase = PH_AFTER;
          post_event(KIND_ACCEPT, ps_addr, 8'h00, ERR_NONE);
        end
      end
    endcase
  endfunction

  // expected results of one accepted character
  function automatic void parse_char(in_item_t it);
    logic [7:0] c;
    logic [4:0] hv;
    c = it.char_code;
    if (it.start_of_file) clear_parser();
    if (ps_halted || ps_phase == PH_DONE) return;
    case (ps_phase)
      PH_WAIT: begin
        if (c == CharNewline) begin
          raise_error(ERR_NO_START);
        end else if (c == CharColon) begin
          ps_phase  = PH_COUNT;
          ps_second = 1'b0;
          ps_high   = 4'h0;
          ps_sum    = 8'h00;
          ps_addr   = 16'h0000;
          ps_count  = 8'h00;
          ps_left   = 8'h00;
          ps_offset = 8'h00;
        end
      end
      PH_AFTER: begin
        if (c == CharNewline) begin
          ps_phase = PH_WAIT;
          ps_count = 8'h00;
          ps_addr  = 16'h0000;
        end
      end
      default: begin
        hv = hex_nibble(c);
        if (c == CharNewline) begin
          raise_error(ERR_TRUNCATED);
        end else if (!hv[4]) begin
          raise_error(field_error());
        end else if (!ps_second) begin
          ps_high   = hv[3:0];
          ps_second = 1'b1;
        end else begin
          ps_second = 1'b0;
          take_byte({ps_high, hv[3:0]});
        end
      end
    endcase
  endfunction

  // stimulus helpers
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + n;
  endfunction

  function automatic logic [7:0] stray_char(bit colon_ok, bit hex_ok);
    logic [7:0] c;
    logic [4:0] hv;
    do begin
      c  = 8'($urandom_range(0, 255));
      hv = hex_nibble(c);
    end while (c == CharNewline || (!colon_ok && c == CharColon) || (!hex_ok && hv[4]));
    return c;
  endfunction

  function automatic bit take_break();
    if (cycle_count >= QuietFirst && cycle_count < QuietLast) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("kind=%0d addr=%h data=%h len=%h err=%0d line=%0d", r.kind,
                     r.address, r.data_byte, r.record_length, r.error_code, r.line_number);
  endfunction

  // fixed text, start of file on its first character
  task automatic add_text(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.start_of_file = (i == 0);
      it.char_code     = s[i];
      char_feed = {char_feed, it};
    end
  endtask

  // one random line: mostly well-formed records, some broken ones and noise
  task automatic add_line(int forced_count);
    logic [7:0]  chars[$];
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [7:0]  rtype;
    logic [15:0] addr;
    in_item_t    it;
    int          count;
    int          roll;
    int          fault;
    int          pos;
    bit          sof;
    bit          upset;

    sof   = gen_halted ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
    upset = 1'b0;
    roll  = $urandom_range(0, 99);
    if (roll < 4) begin
      // noise, any byte value
      repeat ($urandom_range(1, 10)) chars = {chars, 8'($urandom_range(0, 255))};
      upset = 1'b1;
    end else if (roll < 9) begin
      // line with no colon
      repeat ($urandom_range(0, 5)) chars = {chars, stray_char(1'b0, 1'b1)};
      upset = 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 4)) chars = {chars, stray_char(1'b0, 1'b1)};
      roll = $urandom_range(0, 99);
      if (forced_count >= 0) count = forced_count;
      else if (roll < 60) count = $urandom_range(0, 4);
      else if (roll < 90) count = $urandom_range(5, 16);
      else count = $urandom_range(17, 40);
      // addresses near the top wrap inside the record
      addr = ($urandom_range(0, 4) == 0) ? 16'hfff8 + 16'($urandom_range(0, 7))
                                         : 16'($urandom);
      roll  = $urandom_range(0, 99);
      rtype = (roll < 6) ? RecTypeEof : (roll < 11) ? 8'($urandom_range(2, 255)) : RecTypeData;
      body = {body, 8'(count)};
      body = {body, addr[15:8]};
      body = {body, addr[7:0]};
      body = {body, rtype};
      repeat (count) body = {body, 8'($urandom)};
      sum = 8'h00;
      foreach (body[i]) sum = sum + body[i];
      fault = $urandom_range(0, 99);
      if (fault < 8) body = {body, 8'(8'h00 - sum + 8'($urandom_range(1, 255)))};
      else body = {body, 8'(8'h00 - sum)};
      upset = (rtype != RecTypeData) || (fault < 19);
      chars = {chars, CharColon};
      pos = chars.size();
      foreach (body[i]) begin
        chars = {chars, hex_char(body[i][7:4])};
        chars = {chars, hex_char(body[i][3:0])};
      end
      if (fault >= 8 && fault < 14) begin
        // bad character in some field
        pos  = $urandom_range(pos, chars.size() - 1);
        roll = $urandom_range(0, 2);
        chars[pos] = (roll == 0) ? CharColon : (roll == 1) ? CharReturn
                                             : stray_char(1'b1, 1'b0);
      end else if (fault >= 14 && fault < 19) begin
        // line cut short
        pos = $urandom_range(pos, chars.size() - 1);
        while (chars.size() > pos) void'(chars.pop_back());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30) chars = {chars, CharReturn};
        else if (roll < 40)
          repeat ($urandom_range(1, 3)) chars = {chars, stray_char(1'b1, 1'b1)};
      end
    end
    chars = {chars, CharNewline};

    foreach (chars[i]) begin
      it.start_of_file = (i == 0 && sof) || ($urandom_range(0, 299) == 0);
      it.char_code     = chars[i];
      char_feed = {char_feed, it};
    end
    if (sof || !gen_halted) stim_count += chars.size();
    gen_halted = sof ? upset : (gen_halted || upset);
  endtask

  // driver: hold each character until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || char_taken) begin
        if (char_feed.size() != 0 && !take_break()) begin
          in_item_i <= char_feed.pop_front();
          push      <= 1'b1;
        end else begin
          in_item_i <= 9'($urandom);
          push      <= 1'b0;
        end
      end
      pop <= !take_break();
    end
  end

  // accepted characters feed the predictor; run limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      char_taken  <= push && !full;
      if (push && !full) parse_char(in_item_i);
      if (cycle_count > CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %s", $time,
                 show(out_item_o));
      end else begin
        want = pending_events.pop_front();
        if (want.kind !== out_item_o.kind || want.address !== out_item_o.address ||
            want.data_byte !== out_item_o.data_byte ||
            want.record_length !== out_item_o.record_length ||
            want.error_code !== out_item_o.error_code ||
            want.line_number !== out_item_o.line_number) begin
          mismatch_count++;
          $display("%0t: result mismatch, expected %s, actual %s", $time, show(want),
                   show(out_item_o));
        end
      end
    end
  end

  initial begin
    int line_idx;
    clear_parser();

    // directed: line with no colon, empty data record, end of file at top address
    add_text("\n");
    add_text(":0000000000\n");
    add_text(":00FFff01");
    gen_halted = 1'b1;

    // random lines, one of them with the largest byte count
    line_idx = 0;
    while (stim_count < CharTarget) begin
      add_line((line_idx == 30) ? 255 : -1);
      line_idx++;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain
    while (char_feed.size() != 0 || push || pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- intel_hex_record_parser.f -----
+incdir+design
design/ihex_pkg.sv
design/ihex_front.sv
design/ihex_back.sv
design/intel_hex_record_parser.sv
design/ihex_checker.sv
tb/testbench.sv
